// ===== rtl/hfja_pkg.sv =====
package hfja_pkg;

  localparam int IDX_W  = 16;
  localparam int VAL_W  = 64;
  localparam int MASS_W = 32;
  localparam int SH_W   = 9;
  localparam int T_W    = 7;

  localparam logic       ACT_LOAD    = 1'b0;
  localparam logic [1:0] LAST_C      = 2'd2;
  localparam logic [63:0] FORCE_THREE = 64'd3;

  typedef struct packed {
    logic                     action;
    logic [IDX_W-1:0]         particle_index;
    logic signed [VAL_W-1:0]  pos_x;
    logic signed [VAL_W-1:0]  pos_y;
    logic signed [VAL_W-1:0]  pos_z;
    logic signed [VAL_W-1:0]  vel_x;
    logic signed [VAL_W-1:0]  vel_y;
    logic signed [VAL_W-1:0]  vel_z;
    logic [MASS_W-1:0]        mass;
    logic                     last_source;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         target_index;
    logic signed [VAL_W-1:0]  acc_x;
    logic signed [VAL_W-1:0]  acc_y;
    logic signed [VAL_W-1:0]  acc_z;
    logic signed [VAL_W-1:0]  jerk_x;
    logic signed [VAL_W-1:0]  jerk_y;
    logic signed [VAL_W-1:0]  jerk_z;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUB, ST_LD, ST_MUL, ST_MWB, ST_SOFT, ST_NORM,
    ST_SQRT, ST_DIV, ST_RSQ, ST_RCU, ST_MR, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_R2, OP_RV, OP_U, OP_U3, OP_W, OP_ACC, OP_JERK
  } op_t;

endpackage

// ===== rtl/hermite_force_jerk_accumulator_unit.sv =====
// flow: a target load is taken in the idle state, which it does not leave; a source result is
// computed by the shared 32x32 multiplier (4 partial products), the 2-bit normalising
// shifter (0 to 32 steps), the 32-step square root and the 32-step divider in turn.
// one transaction at a time: a source, a self source or a zero distance source holds the input
// closed until it is done, plus any wait on a stalled result
// reset: synchronous active-low rst_n clears control, target state, sums and softening
module hermite_force_jerk_accumulator_unit
  import hfja_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam logic signed [63:0] SMAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SMIN = {1'b1, {63{1'b0}}};

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] scale_sat(input logic [127:0] p, input logic neg,
                                                   input logic signed [SH_W-1:0] sh);
    logic [191:0] e;
    logic [7:0]   amt;
    if (sh < 0) begin
      amt = 8'(-sh);
      e   = {64'b0, p} << amt;
    end else begin
      amt = 8'(sh);
      e   = {64'b0, p} >> amt;
    end
    if (|e[191:63]) return neg ? SMIN : SMAX;
    return neg ? 64'(-e[63:0]) : e[63:0];
  endfunction

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [1:0] c_r, c_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [4:0] dcnt_r, dcnt_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r, out_data_nxt;
  logic [31:0] soft_r, soft_nxt;

  logic signed [63:0] tgt_pos_r [3], tgt_pos_nxt [3];
  logic signed [63:0] tgt_vel_r [3], tgt_vel_nxt [3];
  logic signed [63:0] src_pos_r [3], src_pos_nxt [3];
  logic signed [63:0] src_vel_r [3], src_vel_nxt [3];
  logic signed [63:0] dr_r [3], dr_nxt [3];
  logic signed [63:0] dv_r [3], dv_nxt [3];
  logic signed [63:0] acc_r [3], acc_nxt [3];
  logic signed [63:0] jerk_r [3], jerk_nxt [3];
  logic [IDX_W-1:0]   tgt_id_r, tgt_id_nxt;
  logic [31:0]        mass_r, mass_nxt;

  logic [63:0]  ma_r, ma_nxt, mb_r, mb_nxt;
  logic         neg_r, neg_nxt;
  logic signed [SH_W-1:0] sh_r, sh_nxt;
  logic [127:0] prod_r, prod_nxt;
  logic [127:0] r2_r, r2_nxt;
  logic signed [T_W-1:0] t_r, t_nxt;
  logic [63:0]  n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [32:0]  rem_r, rem_nxt;
  logic [31:0]  q_r, q_nxt, rsq_r, rsq_nxt, rcu_r, rcu_nxt;
  logic [63:0]  mr_r, mr_nxt;
  logic signed [63:0] rv_r, rv_nxt, u3_r, u3_nxt, y_r, y_nxt;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  pp;
  logic signed [63:0] mres;
  logic signed [SH_W-1:0] t_ext;
  logic [63:0]  sq_try;
  logic [32:0]  rem_sh;

  assign pp        = mul_a * mul_b;
  assign mres      = scale_sat(prod_r, neg_r, sh_r);
  assign t_ext     = SH_W'(t_r);
  assign sq_try    = res_r + bit_r;
  assign rem_sh    = {rem_r[31:0], 1'b1};
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;   op_nxt = op_r;     c_nxt = c_r;     cnt_nxt = cnt_r;
    dcnt_nxt = dcnt_r;     last_nxt = last_r; soft_nxt = soft_r;
    out_valid_nxt = out_valid_r; out_data_nxt = out_data_r;
    tgt_pos_nxt = tgt_pos_r; tgt_vel_nxt = tgt_vel_r;
    src_pos_nxt = src_pos_r; src_vel_nxt = src_vel_r;
    dr_nxt = dr_r; dv_nxt = dv_r; acc_nxt = acc_r; jerk_nxt = jerk_r;
    tgt_id_nxt = tgt_id_r; mass_nxt = mass_r;
    ma_nxt = ma_r; mb_nxt = mb_r; neg_nxt = neg_r; sh_nxt = sh_r;
    prod_nxt = prod_r; r2_nxt = r2_r; t_nxt = t_r;
    n_nxt = n_r; res_nxt = res_r; bit_nxt = bit_r; rem_nxt = rem_r; q_nxt = q_r;
    rsq_nxt = rsq_r; rcu_nxt = rcu_r; mr_nxt = mr_r;
    rv_nxt = rv_r; u3_nxt = u3_r; y_nxt = y_r;
    mul_a = '0; mul_b = '0;

    if (cfg_valid) soft_nxt = cfg_data;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.action == ACT_LOAD) begin
            tgt_id_nxt = in_data.particle_index;
            tgt_pos_nxt[0] = in_data.pos_x; tgt_pos_nxt[1] = in_data.pos_y;
            tgt_pos_nxt[2] = in_data.pos_z;
            tgt_vel_nxt[0] = in_data.vel_x; tgt_vel_nxt[1] = in_data.vel_y;
            tgt_vel_nxt[2] = in_data.vel_z;
            for (int i = 0; i < 3; i++) begin
              acc_nxt[i]  = '0;
              jerk_nxt[i] = '0;
            end
          end else begin
            src_pos_nxt[0] = in_data.pos_x; src_pos_nxt[1] = in_data.pos_y;
            src_pos_nxt[2] = in_data.pos_z;
            src_vel_nxt[0] = in_data.vel_x; src_vel_nxt[1] = in_data.vel_y;
            src_vel_nxt[2] = in_data.vel_z;
            mass_nxt = in_data.mass;
            last_nxt = in_data.last_source;
            c_nxt    = '0;
            if (in_data.particle_index == tgt_id_r) state_nxt = ST_FIN;
            else state_nxt = ST_SUB;
          end
        end
      end
      ST_SUB: begin
        dr_nxt[c_r] = sat_sub(src_pos_r[c_r], tgt_pos_r[c_r]);
        dv_nxt[c_r] = sat_sub(src_vel_r[c_r], tgt_vel_r[c_r]);
        if (c_r == LAST_C) begin
          c_nxt = '0; op_nxt = OP_R2; r2_nxt = '0; state_nxt = ST_LD;
        end else begin
          c_nxt = c_r + 2'd1;
        end
      end
      ST_LD: begin
        prod_nxt = '0; cnt_nxt = '0; state_nxt = ST_MUL;
        neg_nxt = 1'b0; sh_nxt = '0;
        case (op_r)
          OP_R2: begin
            ma_nxt = mag(dr_r[c_r]); mb_nxt = mag(dr_r[c_r]);
          end
          OP_RV: begin
            ma_nxt = mag(dr_r[c_r]); mb_nxt = mag(dv_r[c_r]);
            neg_nxt = dr_r[c_r][63] ^ dv_r[c_r][63]; sh_nxt = SH_W'(32);
          end
          OP_U: begin
            ma_nxt = mag(rv_r); mb_nxt = {32'b0, rsq_r};
            neg_nxt = rv_r[63]; sh_nxt = SH_W'(30) + (t_ext <<< 1);
          end
          OP_U3: begin
            ma_nxt = mag(u3_r); mb_nxt = FORCE_THREE; neg_nxt = u3_r[63];
          end
          OP_W: begin
            ma_nxt = mag(u3_r); mb_nxt = mag(dr_r[c_r]);
            neg_nxt = u3_r[63] ^ dr_r[c_r][63]; sh_nxt = SH_W'(32);
          end
          OP_ACC: begin
            ma_nxt = mag(dr_r[c_r]); mb_nxt = mr_r; neg_nxt = dr_r[c_r][63];
            sh_nxt = SH_W'(61) + t_ext + (t_ext <<< 1);
          end
          default: begin
            ma_nxt = mag(y_r); mb_nxt = mr_r; neg_nxt = y_r[63];
            sh_nxt = SH_W'(61) + t_ext + (t_ext <<< 1);
          end
        endcase
      end
      ST_MUL: begin
        mul_a = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
        mul_b = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
        case (cnt_r)
          2'd0:    prod_nxt = prod_r + {64'b0, pp};
          2'd3:    prod_nxt = prod_r + {pp, 64'b0};
          default: prod_nxt = prod_r + {32'b0, pp, 32'b0};
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = ST_MWB;
      end
      ST_MWB: begin
        state_nxt = ST_LD;
        case (op_r)
          OP_R2: begin
            r2_nxt = r2_r + prod_r;
            if (c_r == LAST_C) begin
              c_nxt = '0; state_nxt = ST_SOFT;
            end else c_nxt = c_r + 2'd1;
          end
          OP_RV: begin
            rv_nxt = sat_add(rv_r, mres);
            if (c_r == LAST_C) begin
              c_nxt = '0; op_nxt = OP_U;
            end else c_nxt = c_r + 2'd1;
          end
          OP_U: begin
            u3_nxt = mres; op_nxt = OP_U3;
          end
          OP_U3: begin
            u3_nxt = mres; op_nxt = OP_W; c_nxt = '0;
          end
          OP_W: begin
            y_nxt = sat_sub(dv_r[c_r], mres); op_nxt = OP_ACC;
          end
          OP_ACC: begin
            acc_nxt[c_r] = sat_add(acc_r[c_r], mres); op_nxt = OP_JERK;
          end
          default: begin
            jerk_nxt[c_r] = sat_add(jerk_r[c_r], mres);
            if (c_r == LAST_C) state_nxt = ST_FIN;
            else begin
              c_nxt = c_r + 2'd1; op_nxt = OP_W;
            end
          end
        endcase
      end
      ST_SOFT: begin
        r2_nxt = r2_r + {64'b0, soft_r, 32'b0};
        t_nxt = '0;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (r2_r == '0) state_nxt = ST_FIN;
        else if (|r2_r[127:64]) begin
          r2_nxt = r2_r >> 2; t_nxt = t_r + T_W'(1);
        end else if (r2_r[63:62] == 2'b00) begin
          r2_nxt = r2_r << 2; t_nxt = t_r - T_W'(1);
        end else begin
          n_nxt = r2_r[63:0]; res_nxt = '0; bit_nxt = 64'h4000_0000_0000_0000;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (n_r >= sq_try) begin
          n_nxt = n_r - sq_try; res_nxt = (res_r >> 1) + bit_r;
        end else res_nxt = res_r >> 1;
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          rem_nxt = 33'h0_7FFF_FFFF; q_nxt = '0; dcnt_nxt = '0; state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, res_r[31:0]}) begin
          rem_nxt = rem_sh - {1'b0, res_r[31:0]}; q_nxt = {q_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh; q_nxt = {q_r[30:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) state_nxt = ST_RSQ;
      end
      ST_RSQ: begin
        mul_a = q_r; mul_b = q_r; rsq_nxt = pp[63:32]; state_nxt = ST_RCU;
      end
      ST_RCU: begin
        mul_a = rsq_r; mul_b = q_r; rcu_nxt = pp[63:32]; state_nxt = ST_MR;
      end
      ST_MR: begin
        mul_a = mass_r; mul_b = rcu_r; mr_nxt = pp;
        rv_nxt = '0; c_nxt = '0; op_nxt = OP_RV; state_nxt = ST_LD;
      end
      ST_FIN: begin
        if (!last_r) state_nxt = ST_IDLE;
        else if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.target_index = tgt_id_r;
          out_data_nxt.acc_x  = acc_r[0];  out_data_nxt.acc_y  = acc_r[1];
          out_data_nxt.acc_z  = acc_r[2];
          out_data_nxt.jerk_x = jerk_r[0]; out_data_nxt.jerk_y = jerk_r[1];
          out_data_nxt.jerk_z = jerk_r[2];
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= OP_R2;
      c_r <= '0;
      cnt_r <= '0;
      dcnt_r <= '0;
      last_r <= 1'b0;
      out_valid_r <= 1'b0;
      soft_r <= '0;
      tgt_id_r <= '0;
      for (int i = 0; i < 3; i++) begin
        tgt_pos_r[i] <= '0;
        tgt_vel_r[i] <= '0;
        acc_r[i] <= '0;
        jerk_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      c_r <= c_nxt;
      cnt_r <= cnt_nxt;
      dcnt_r <= dcnt_nxt;
      last_r <= last_nxt;
      out_valid_r <= out_valid_nxt;
      soft_r <= soft_nxt;
      tgt_id_r <= tgt_id_nxt;
      tgt_pos_r <= tgt_pos_nxt;
      tgt_vel_r <= tgt_vel_nxt;
      acc_r <= acc_nxt;
      jerk_r <= jerk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    src_pos_r <= src_pos_nxt;
    src_vel_r <= src_vel_nxt;
    dr_r <= dr_nxt;
    dv_r <= dv_nxt;
    mass_r <= mass_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    neg_r <= neg_nxt;
    sh_r <= sh_nxt;
    prod_r <= prod_nxt;
    r2_r <= r2_nxt;
    t_r <= t_nxt;
    n_r <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    rsq_r <= rsq_nxt;
    rcu_r <= rcu_nxt;
    mr_r <= mr_nxt;
    rv_r <= rv_nxt;
    u3_r <= u3_nxt;
    y_r <= y_nxt;
  end

endmodule

// ===== rtl/hfja_chk.sv =====
module hfja_chk
  import hfja_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input in_t         in_data,
  input logic        out_valid,
  input logic        out_ready,
  input out_t        out_data
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a target load never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == ACT_LOAD && !out_valid |=> !out_valid)
    else $error("target load produced a result");

  // a source transaction closes the input in the cycle after it is taken
  a_src_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action != ACT_LOAD |=> !in_ready)
    else $error("source transaction did not hold off input");

  // results only appear out of a busy period
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work");

endmodule

bind hermite_force_jerk_accumulator_unit hfja_chk u_hfja_chk (.*);

// ===== tb/hermite_force_jerk_checker.sv =====
`timescale 1ns / 100ps
module hermite_force_jerk_checker
  import hfja_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          mismatch_count,
  output int          sums_pending,
  output int          sums_seen
);

  localparam logic signed [63:0] MAX64 = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

  logic [31:0]        soft_sq;
  logic signed [63:0] tgt_pos [3];
  logic signed [63:0] tgt_vel [3];
  logic [IDX_W-1:0]   tgt_id;
  logic signed [63:0] acc [3];
  logic signed [63:0] jrk [3];
  out_t               expected_sums [$];

  function automatic logic signed [63:0] clamp(logic signed [65:0] v);
    if (v > MAX64) return MAX64;
    if (v < MIN64) return MIN64;
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [65:0] s;
    s = a + b;
    return clamp(s);
  endfunction

  function automatic logic signed [63:0] sub_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [65:0] s;
    s = a - b;
    return clamp(s);
  endfunction

  function automatic logic signed [63:0] scaled_mul(logic signed [63:0] a, logic [63:0] mb,
                                                    logic bneg, int sh);
    logic [63:0]  mag;
    logic [255:0] w;
    logic         neg;
    mag = a[63] ? -a : a;
    neg = a[63] ^ bneg;
    w = 256'(mag) * 256'(mb);
    if (sh >= 128) w = '0;
    else if (sh > 0) w = w >> sh;
    else if (sh < 0) w = w << (-sh);
    if (w[255:63] != 0) return neg ? MIN64 : MAX64;
    return neg ? -w[63:0] : w[63:0];
  endfunction

  function automatic logic signed [63:0] signed_mul(logic signed [63:0] a, logic signed [63:0] b,
                                                    int sh);
    logic [63:0] mb;
    mb = b[63] ? -b : b;
    return scaled_mul(a, mb, b[63], sh);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  task automatic add_pair_force(logic signed [63:0] sp [3], logic signed [63:0] sv [3],
                                logic [31:0] m);
    logic signed [63:0] dr [3];
    logic signed [63:0] dv [3];
    logic [127:0]       r2;
    logic [127:0]       shifted;
    logic [63:0]        n, s, r, rsq, rcu, mr, dm;
    logic signed [63:0] rv, u3, w, y;
    int                 p, sh, t;
    r2 = 0;
    for (int c = 0; c < 3; c++) begin
      dr[c] = sub_sat(sp[c], tgt_pos[c]);
      dv[c] = sub_sat(sv[c], tgt_vel[c]);
      dm = dr[c][63] ? -dr[c] : dr[c];
      r2 = r2 + 128'(dm) * 128'(dm);
    end
    r2 = r2 + (128'(soft_sq) << 32);
    if (r2 == 0) return;
    p = 0;
    for (int i = 0; i < 128; i++) if (r2[i]) p = i;
    sh = p - 63;
    if ((p & 1) == 0) sh = sh + 1;
    shifted = (sh < 0) ? (r2 << (-sh)) : (r2 >> sh);
    n = shifted[63:0];
    t = sh / 2;
    s = int_sqrt(n);
    r = 64'h7fff_ffff_ffff_ffff / s;
    rsq = (r * r) >> 32;
    rcu = (rsq * r) >> 32;
    mr = 64'(m) * rcu;
    rv = 0;
    for (int c = 0; c < 3; c++) rv = add_sat(rv, signed_mul(dr[c], dv[c], 32));
    u3 = scaled_mul(rv, rsq, 1'b0, 30 + 2 * t);
    u3 = scaled_mul(u3, FORCE_THREE, 1'b0, 0);
    for (int c = 0; c < 3; c++) begin
      w = signed_mul(u3, dr[c], 32);
      y = sub_sat(dv[c], w);
      acc[c] = add_sat(acc[c], scaled_mul(dr[c], mr, 1'b0, 61 + 3 * t));
      jrk[c] = add_sat(jrk[c], scaled_mul(y, mr, 1'b0, 61 + 3 * t));
    end
  endtask

  task automatic predict_sums(in_t it);
    logic signed [63:0] p3 [3];
    logic signed [63:0] v3 [3];
    out_t               o;
    p3 = '{it.pos_x, it.pos_y, it.pos_z};
    v3 = '{it.vel_x, it.vel_y, it.vel_z};
    if (it.action == ACT_LOAD) begin
      tgt_id = it.particle_index;
      for (int c = 0; c < 3; c++) begin
        tgt_pos[c] = p3[c];
        tgt_vel[c] = v3[c];
        acc[c] = 0;
        jrk[c] = 0;
      end
      return;
    end
    if (it.particle_index != tgt_id) add_pair_force(p3, v3, it.mass);
    if (!it.last_source) return;
    o.target_index = tgt_id;
    o.acc_x = acc[0];
    o.acc_y = acc[1];
    o.acc_z = acc[2];
    o.jerk_x = jrk[0];
    o.jerk_y = jrk[1];
    o.jerk_z = jrk[2];
    expected_sums.push_back(o);
  endtask

  task automatic check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s expected %h got %h", $realtime, fname, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      soft_sq <= 0;
      tgt_id = 0;
      for (int c = 0; c < 3; c++) begin
        tgt_pos[c] = 0;
        tgt_vel[c] = 0;
        acc[c] = 0;
        jrk[c] = 0;
      end
      expected_sums.delete();
    end else begin
      if (in_valid && in_ready) predict_sums(in_data);
      if (cfg_valid && cfg_ready) soft_sq <= cfg_data;
      if (out_valid && out_ready) begin
        sums_seen++;
        if (expected_sums.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected transaction, target %h", $realtime,
                     out_data.target_index);
        end else begin
          e = expected_sums.pop_front();
          check_field("target_index", 64'(e.target_index), 64'(out_data.target_index));
          check_field("acc_x", e.acc_x, out_data.acc_x);
          check_field("acc_y", e.acc_y, out_data.acc_y);
          check_field("acc_z", e.acc_z, out_data.acc_z);
          check_field("jerk_x", e.jerk_x, out_data.jerk_x);
          check_field("jerk_y", e.jerk_y, out_data.jerk_y);
          check_field("jerk_z", e.jerk_z, out_data.jerk_z);
        end
      end
    end
    sums_pending = expected_sums.size();
  end

  initial begin
    mismatch_count = 0;
    sums_pending = 0;
    sums_seen = 0;
  end

endmodule

// ===== tb/tb_hermite_force_jerk_accumulator_unit.sv =====
`timescale 1ns / 100ps
module tb_hermite_force_jerk_accumulator_unit;
  import hfja_pkg::*;

  localparam logic ACT_SOURCE = ~ACT_LOAD;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  int mismatch_count;
  int sums_pending;
  int sums_seen;
  int items_sent;
  int idle_pct;
  int stall_pct;
  logic [IDX_W-1:0] cur_target;

  hermite_force_jerk_accumulator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  hermite_force_jerk_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .sums_pending   (sums_pending),
    .sums_seen      (sums_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // signed value of roughly the given bit span
  function automatic logic [63:0] rnd_val(int bits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (bits >= 64) return r;
    return $signed(r) >>> (64 - bits);
  endfunction

  function automatic in_t make_item(logic act, logic [IDX_W-1:0] idx, logic [63:0] px,
                                    logic [63:0] py, logic [63:0] pz, logic [63:0] vx,
                                    logic [63:0] vy, logic [63:0] vz, logic [31:0] m,
                                    logic lst);
    in_t it;
    it.action = act;
    it.particle_index = idx;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.vel_x = vx;
    it.vel_y = vy;
    it.vel_z = vz;
    it.mass = m;
    it.last_source = lst;
    return it;
  endfunction

  task automatic send(in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_and_config(logic [31:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (260) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_source(int span, logic lst);
    logic [IDX_W-1:0] idx;
    int               vspan;
    idx = ($urandom_range(9) == 0) ? cur_target : IDX_W'($urandom);
    vspan = $urandom_range(8, 40);
    send(make_item(ACT_SOURCE, idx, rnd_val(span), rnd_val(span), rnd_val(span),
                   rnd_val(vspan), rnd_val(vspan), rnd_val(vspan), $urandom, lst));
  endtask

  task automatic run_random(int count);
    int stop_at, nsrc, span;
    in_t it;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        span = $urandom_range(0, 4) == 0 ? 64 : $urandom_range(20, 40);
        cur_target = IDX_W'($urandom);
        send(make_item(ACT_LOAD, cur_target, rnd_val(span), rnd_val(span), rnd_val(span),
                       rnd_val(30), rnd_val(30), rnd_val(30), $urandom, $urandom_range(1)));
        nsrc = $urandom_range(1, 5);
        for (int k = 0; k < nsrc; k++) send_random_source(span, k == nsrc - 1);
      end else begin
        it = make_item($urandom_range(1), IDX_W'($urandom), rnd_val(64), rnd_val(64),
                       rnd_val(64), rnd_val(64), rnd_val(64), rnd_val(64), $urandom,
                       $urandom_range(1));
        if (it.action == ACT_LOAD) cur_target = it.particle_index;
        send(it);
      end
    end
  endtask

  initial begin
    logic [63:0] one;
    logic [63:0] pmax;
    logic [63:0] pmin;
    one = 64'd1 << 32;
    pmax = 64'h7fff_ffff_ffff_ffff;
    pmin = 64'h8000_0000_0000_0000;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_data = '0;
    out_ready = 1;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    cur_target = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // source before any target, then a load that carries the last mark
    send(make_item(ACT_SOURCE, 16'd5, one, 0, 0, 0, one, 0, 32'hffff_ffff, 1'b1));
    send(make_item(ACT_LOAD, 16'd0, 0, 0, 0, 0, 0, 0, 32'hffff_ffff, 1'b1));
    send(make_item(ACT_SOURCE, 16'hffff, one, one, one, one, 0, 0, 32'h8000_0000, 1'b1));
    // self source and zero distance without softening
    send(make_item(ACT_SOURCE, 16'd0, one, 0, 0, 0, 0, 0, 32'hffff_ffff, 1'b1));
    send(make_item(ACT_SOURCE, 16'd7, 0, 0, 0, one, one, one, 32'hffff_ffff, 1'b1));
    // field extremes and overflow
    send(make_item(ACT_LOAD, 16'hffff, pmin, pmin, pmin, pmin, pmin, pmin, 0, 1'b0));
    send(make_item(ACT_SOURCE, 16'd1, pmax, pmax, pmax, pmax, pmax, pmax, 32'hffff_ffff,
                   1'b0));
    send(make_item(ACT_SOURCE, 16'd2, pmin, pmax, 0, pmax, pmin, 0, 0, 1'b1));
    send(make_item(ACT_LOAD, 16'd3, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send(make_item(ACT_SOURCE, 16'd4, 64'd1, 0, 0, 0, 64'd1, 0, 32'hffff_ffff, 1'b0));
    for (int k = 0; k < 5; k++)
      send(make_item(ACT_SOURCE, 16'd4, 64'd1, 64'd1, 64'd1, pmax, 0, pmin, 32'hffff_ffff,
                     k == 4));
    send(make_item(ACT_SOURCE, 16'd9, rnd_val(64), rnd_val(64), rnd_val(64), rnd_val(64),
                   rnd_val(64), rnd_val(64), $urandom, 1'b1));

    // extreme softening with zero distance, then a range of settings
    drain_and_config(32'hffff_ffff);
    send(make_item(ACT_LOAD, 16'd3, one, one, one, 0, 0, 0, 0, 1'b0));
    send(make_item(ACT_SOURCE, 16'd8, one, one, one, one, 0, pmin, 32'hffff_ffff, 1'b1));

    drain_and_config(32'd0);
    run_random(225);
    drain_and_config(32'hffff_ffff);
    idle_pct = 49;
    run_random(225);
    drain_and_config($urandom);
    idle_pct = 0;
    stall_pct = 49;
    run_random(225);
    drain_and_config(32'd1);
    idle_pct = 6;
    stall_pct = 6;
    run_random(225);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d input transactions and %0d result transactions", items_sent,
             sums_seen);
    $display("softening at zero, full scale, random and one, under four idle patterns");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hfja_pkg.sv
rtl/hermite_force_jerk_accumulator_unit.sv
rtl/hfja_chk.sv
tb/hermite_force_jerk_checker.sv
tb/tb_hermite_force_jerk_accumulator_unit.sv
